// File: rtl/core/cle_pkg.sv
// cle_pkg: shared widths, operation codes, controller states and the
// command struct that drives the character stacks of the line editor
// no dependencies
`default_nettype none

package cle_pkg;

  // fixed field widths
  localparam int CHAR_W  = 8;
  localparam int OP_W    = 3;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;

  // default buffer capacity in characters
  localparam int CAPACITY_DEF = 1024;

  // operation codes of an input beat
  typedef enum logic [OP_W-1:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_DELETE = 3'd2,
    OP_INSERT = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_DONE
  } state_t;

  // per-cycle command to one stack of cells
  typedef struct packed {
    logic push;   // shift chars away from the head, new char enters cell 0
    logic pop;    // shift chars toward the head
    logic load;   // copy every char into its reply register
    logic shift;  // move reply registers one cell toward the head
  } stack_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/cle_in_if.sv
// cle_in_if: input channel of the line editor, valid/ready plus request fields
// depends on cle_pkg
`default_nettype none

interface cle_in_if;
  logic                        valid;
  logic                        ready;
  logic [cle_pkg::OP_W-1:0]    operation;
  logic [cle_pkg::CHAR_W-1:0]  char_in;
  logic [cle_pkg::POS_W-1:0]   read_position;

  modport source (output valid, output operation, output char_in,
                  output read_position, input ready);
  modport sink   (input valid, input operation, input char_in,
                  input read_position, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cle_out_if.sv
// cle_out_if: result channel of the line editor, valid/ready plus result fields
// depends on cle_pkg
`default_nettype none

interface cle_out_if;
  logic                         valid;
  logic                         ready;
  logic [cle_pkg::CHAR_W-1:0]   char_out;
  logic [cle_pkg::COUNT_W-1:0]  text_length;
  logic [cle_pkg::COUNT_W-1:0]  cursor_position;
  logic                         refused;

  modport source (output valid, output char_out, output text_length,
                  output cursor_position, output refused, input ready);
  modport sink   (input valid, input char_out, input text_length,
                  input cursor_position, input refused, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cle_cell.sv
// cle_cell: one storage cell of a character stack, holding one char and one
// reply byte that both move to the neighbor cells on command
// depends on cle_pkg
`default_nettype none

module cle_cell (
  input  wire logic                       clk,
  input  wire cle_pkg::stack_cmd_t        cmd,
  input  wire logic [cle_pkg::CHAR_W-1:0] head_char,   // from cell nearer the head
  input  wire logic [cle_pkg::CHAR_W-1:0] tail_char,   // from cell farther down
  input  wire logic [cle_pkg::CHAR_W-1:0] tail_reply,  // reply of cell farther down
  output logic      [cle_pkg::CHAR_W-1:0] char_o,
  output logic      [cle_pkg::CHAR_W-1:0] reply_o
);

  logic [cle_pkg::CHAR_W-1:0] char_r;
  logic [cle_pkg::CHAR_W-1:0] reply_r;

  // stored char: push moves down, pop moves up
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      char_r <= head_char;
    end else if (cmd.pop) begin
      char_r <= tail_char;
    end
  end

  // reply byte: snapshot of the char, then marches toward the head
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      reply_r <= char_r;
    end else if (cmd.shift) begin
      reply_r <= tail_reply;
    end
  end

  assign char_o  = char_r;
  assign reply_o = reply_r;

endmodule

`default_nettype wire

// File: rtl/core/cle_stack.sv
// cle_stack: a chain of DEPTH cells forming a last-in first-out char stack,
// cell 0 is the top; reads walk reply bytes toward cell 0
// depends on cle_pkg, cle_cell
`default_nettype none

module cle_stack #(
  parameter int DEPTH = cle_pkg::CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire cle_pkg::stack_cmd_t        cmd,
  input  wire logic [cle_pkg::CHAR_W-1:0] push_data,
  output logic      [cle_pkg::CHAR_W-1:0] top_char,
  output logic      [cle_pkg::CHAR_W-1:0] top_reply
);

  logic [cle_pkg::CHAR_W-1:0] char_w  [DEPTH];
  logic [cle_pkg::CHAR_W-1:0] reply_w [DEPTH];

  // row of cells, each wired to its two neighbors
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [cle_pkg::CHAR_W-1:0] head_in;
    logic [cle_pkg::CHAR_W-1:0] tail_in;
    logic [cle_pkg::CHAR_W-1:0] tail_rep;

    if (k == 0) begin : g_head
      assign head_in = push_data;
    end else begin : g_inner_head
      assign head_in = char_w[k-1];
    end

    if (k == DEPTH-1) begin : g_tail
      assign tail_in  = '0;
      assign tail_rep = '0;
    end else begin : g_inner_tail
      assign tail_in  = char_w[k+1];
      assign tail_rep = reply_w[k+1];
    end

    cle_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .head_char  (head_in),
      .tail_char  (tail_in),
      .tail_reply (tail_rep),
      .char_o     (char_w[k]),
      .reply_o    (reply_w[k])
    );
  end

  assign top_char  = char_w[0];
  assign top_reply = reply_w[0];

endmodule

`default_nettype wire

// File: rtl/core/cursor_line_editor.sv
// cursor_line_editor: gap-buffer line editor built from two stacks of cells,
// one for the chars left of the cursor, one for those right of it
// depends on cle_pkg, cle_in_if, cle_out_if, cle_stack
//
//   channel   dir  handshake     fields
//   in_chan   in   valid/ready   operation, char_in, read_position
//   out_chan  out  valid/ready   char_out, text_length, cursor_position, refused
//
// moves, deletes, inserts and refused reads shift the stacks as the beat is
// taken, then hand the result to the output register from the done state
// a read loads the reply bytes, which then walk one cell a cycle toward the
// stack top until the char at the read position reaches it
// rst_n clears the counts, the controller and the output valid; cells hold
// no reset value, every char below the text length has been written
// one new beat is accepted while the previous result stalls in the output

`default_nettype none

module cursor_line_editor #(
  parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cle_in_if.sink    in_chan,
  cle_out_if.source out_chan
);

  localparam int CW = $clog2(CAPACITY + 1);          // count width
  localparam int DW = $clog2(CAPACITY);              // depth width
  localparam int XW = (CW > cle_pkg::POS_W) ? CW : cle_pkg::POS_W;

  cle_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] right_r, right_nxt;
  logic [DW-1:0] cnt_r, cnt_nxt;
  logic          sel_left_r, sel_left_nxt;
  logic [cle_pkg::CHAR_W-1:0] res_char_r, res_char_nxt;
  logic          res_ref_r, res_ref_nxt;

  logic                        out_valid_r;
  logic [cle_pkg::CHAR_W-1:0]  out_char_r;
  logic [cle_pkg::COUNT_W-1:0] out_len_r;
  logic [cle_pkg::COUNT_W-1:0] out_cur_r;
  logic                        out_ref_r;

  cle_pkg::stack_cmd_t        lcmd, rcmd;
  logic [cle_pkg::CHAR_W-1:0] lpush, ltop, lreply;
  logic [cle_pkg::CHAR_W-1:0] rtop, rreply;

  cle_pkg::op_t  op;
  logic          accept;
  logic          out_free;
  logic [CW-1:0] len;
  logic [XW-1:0] pos_x, left_x, len_x;
  logic          rd_fail;
  logic          rd_left;

  // request decode
  assign op       = cle_pkg::op_t'(in_chan.operation);
  assign in_chan.ready = (state_r == cle_pkg::ST_IDLE);
  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign len      = left_r + right_r;
  assign pos_x    = XW'(in_chan.read_position);
  assign left_x   = XW'(left_r);
  assign len_x    = XW'(len);
  assign rd_fail  = (pos_x >= len_x);
  assign rd_left  = (pos_x < left_x);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cle_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == cle_pkg::OP_READ && !rd_fail) begin
            state_nxt = cle_pkg::ST_SEEK;
          end else begin
            state_nxt = cle_pkg::ST_DONE;
          end
        end
      end
      cle_pkg::ST_SEEK: begin
        if (cnt_r == '0) begin
          state_nxt = cle_pkg::ST_DONE;
        end
      end
      cle_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cle_pkg::ST_IDLE;
    endcase
  end

  // stack commands and datapath next values
  always_comb begin
    lcmd         = '0;
    rcmd         = '0;
    lpush        = in_chan.char_in;
    left_nxt     = left_r;
    right_nxt    = right_r;
    cnt_nxt      = cnt_r;
    sel_left_nxt = sel_left_r;
    res_char_nxt = res_char_r;
    res_ref_nxt  = res_ref_r;
    case (state_r)
      cle_pkg::ST_IDLE: begin
        if (accept) begin
          res_char_nxt = '0;
          res_ref_nxt  = 1'b0;
          case (op)
            cle_pkg::OP_LEFT: begin
              if (left_r != '0) begin
                lcmd.pop  = 1'b1;
                rcmd.push = 1'b1;
                left_nxt  = left_r - 1'b1;
                right_nxt = right_r + 1'b1;
              end
            end
            cle_pkg::OP_RIGHT: begin
              if (right_r != '0) begin
                rcmd.pop  = 1'b1;
                lcmd.push = 1'b1;
                lpush     = rtop;
                left_nxt  = left_r + 1'b1;
                right_nxt = right_r - 1'b1;
              end
            end
            cle_pkg::OP_DELETE: begin
              if (left_r != '0) begin
                lcmd.pop = 1'b1;
                left_nxt = left_r - 1'b1;
              end
            end
            cle_pkg::OP_INSERT: begin
              if (len >= CW'(CAPACITY)) begin
                res_ref_nxt = 1'b1;
              end else begin
                lcmd.push = 1'b1;
                left_nxt  = left_r + 1'b1;
              end
            end
            cle_pkg::OP_READ: begin
              if (rd_fail) begin
                res_ref_nxt = 1'b1;
              end else begin
                lcmd.load    = 1'b1;
                rcmd.load    = 1'b1;
                sel_left_nxt = rd_left;
                if (rd_left) begin
                  cnt_nxt = DW'(left_x - pos_x - 1'b1);
                end else begin
                  cnt_nxt = DW'(pos_x - left_x);
                end
              end
            end
            default: begin
              // unused codes leave the stacks and counts alone
            end
          endcase
        end
      end
      cle_pkg::ST_SEEK: begin
        if (cnt_r == '0) begin
          res_char_nxt = sel_left_r ? lreply : rreply;
        end else begin
          lcmd.shift = 1'b1;
          rcmd.shift = 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      default: begin
        // done state only waits for the output register
      end
    endcase
  end

  // controller and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cle_pkg::ST_IDLE;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    sel_left_r <= sel_left_nxt;
    res_char_r <= res_char_nxt;
    res_ref_r  <= res_ref_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == cle_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cle_pkg::ST_DONE && out_free) begin
      out_char_r <= res_char_r;
      out_len_r  <= cle_pkg::COUNT_W'(len);
      out_cur_r  <= cle_pkg::COUNT_W'(left_r);
      out_ref_r  <= res_ref_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.char_out        = out_char_r;
  assign out_chan.text_length     = out_len_r;
  assign out_chan.cursor_position = out_cur_r;
  assign out_chan.refused         = out_ref_r;

  // chars left of the cursor, top is the char just left of it
  cle_stack #(.DEPTH(CAPACITY)) u_left (
    .clk       (clk),
    .cmd       (lcmd),
    .push_data (lpush),
    .top_char  (ltop),
    .top_reply (lreply)
  );

  // chars right of the cursor, top is the char just right of it
  cle_stack #(.DEPTH(CAPACITY)) u_right (
    .clk       (clk),
    .cmd       (rcmd),
    .push_data (ltop),
    .top_char  (rtop),
    .top_reply (rreply)
  );

endmodule

`default_nettype wire

// File: rtl/core/cle_checker.sv
// cle_checker: port-level checks on the result channel of the line editor,
// bound to the top level
// depends on cle_pkg, cursor_line_editor
`default_nettype none

module cle_checker #(
  parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [cle_pkg::CHAR_W-1:0]  char_out,
  input wire logic [cle_pkg::COUNT_W-1:0] text_length,
  input wire logic [cle_pkg::COUNT_W-1:0] cursor_position,
  input wire logic                        refused
);

  localparam bit NO_WRAP = (CAPACITY <= 1024);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(char_out) &&
    $stable(text_length) && $stable(cursor_position) && $stable(refused))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // length never above capacity, cursor never beyond length
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NO_WRAP |->
    (text_length <= cle_pkg::COUNT_W'(CAPACITY)) && (cursor_position <= text_length))
    else $error("counts out of range");

  // a refused beat carries no char
  a_refused_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && refused |-> char_out == '0)
    else $error("refused beat with nonzero char");

endmodule

bind cursor_line_editor cle_checker #(.CAPACITY(CAPACITY)) u_cle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .char_out        (out_chan.char_out),
  .text_length     (out_chan.text_length),
  .cursor_position (out_chan.cursor_position),
  .refused         (out_chan.refused)
);

`default_nettype wire

// File: tb/sv/tb_cursor_line_editor.sv
// tb_cursor_line_editor: self-checking bench for the gap-buffer line editor,
// a queue-based model of the text predicts every result beat
// depends on cle_pkg, cle_in_if, cle_out_if and cursor_line_editor
`timescale 1ns / 100ps

module tb_cursor_line_editor;

  localparam int CAPACITY     = cle_pkg::CAPACITY_DEF;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STALL_LIMIT  = 6000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 40;
  localparam int MIX_BEATS    = 70;
  localparam int TAIL_BEATS   = 30;

  // operation codes the block leaves unused
  localparam logic [cle_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [cle_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [cle_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [cle_pkg::CHAR_W-1:0]  char_out;
    logic [cle_pkg::COUNT_W-1:0] text_length;
    logic [cle_pkg::COUNT_W-1:0] cursor_position;
    logic                        refused;
  } editor_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cle_in_if  in_chan ();
  cle_out_if out_chan ();

  cursor_line_editor #(.CAPACITY(CAPACITY)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #HALF_PERIOD clk = ~clk;

  // text model: the whole line in order, cursor counts chars left of it
  logic [cle_pkg::CHAR_W-1:0] line_text[$];
  int unsigned                cursor_at = 0;

  editor_reply_t pending_replies[$];
  int            error_count = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;
  bit            hold_request = 1'b0;
  bit            hold_taken = 1'b0;
  int            quiet_cycles = 0;

  // apply one edit to the text model and return the reply it calls for
  function automatic editor_reply_t apply_edit(logic [cle_pkg::OP_W-1:0] op,
                                               logic [cle_pkg::CHAR_W-1:0] ch,
                                               logic [cle_pkg::POS_W-1:0] pos);
    editor_reply_t reply;
    reply = '0;
    case (op)
      cle_pkg::OP_LEFT: begin
        if (cursor_at > 0) cursor_at--;
      end
      cle_pkg::OP_RIGHT: begin
        if (cursor_at < line_text.size()) cursor_at++;
      end
      cle_pkg::OP_DELETE: begin
        if (cursor_at > 0) begin
          line_text.delete(cursor_at - 1);
          cursor_at--;
        end
      end
      cle_pkg::OP_INSERT: begin
        if (line_text.size() >= CAPACITY) begin
          reply.refused = 1'b1;
        end else begin
          line_text.insert(cursor_at, ch);
          cursor_at++;
        end
      end
      cle_pkg::OP_READ: begin
        if (pos >= line_text.size()) reply.refused = 1'b1;
        else reply.char_out = line_text[pos];
      end
      default: ;
    endcase
    reply.text_length     = cle_pkg::COUNT_W'(line_text.size());
    reply.cursor_position = cle_pkg::COUNT_W'(cursor_at);
    return reply;
  endfunction

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;  stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct = 75; stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;  stall_pct = 75;
      end
      default: begin
        gap_pct = 33; stall_pct = 33;
      end
    endcase
  endtask

  // offer one beat, predict its reply once it is taken; returns at a falling edge
  task automatic send_edit(logic [cle_pkg::OP_W-1:0] op, logic [cle_pkg::CHAR_W-1:0] ch,
                           logic [cle_pkg::POS_W-1:0] pos);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.operation     <= op;
    in_chan.char_in       <= ch;
    in_chan.read_position <= pos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_replies.push_back(apply_edit(op, ch, pos));
    @(negedge clk);
  endtask

  // one random edit; while filling, inserts dominate
  task automatic send_random_edit(bit filling);
    int                         roll;
    logic [cle_pkg::OP_W-1:0]   op;
    logic [cle_pkg::CHAR_W-1:0] ch;
    logic [cle_pkg::POS_W-1:0]  pos;
    roll = $urandom_range(99, 0);
    ch   = cle_pkg::CHAR_W'($urandom_range(255, 0));
    pos  = cle_pkg::POS_W'($urandom_range(1023, 0));
    if (filling) begin
      if (roll < 5) op = cle_pkg::OP_LEFT;
      else if (roll < 10) op = cle_pkg::OP_RIGHT;
      else if (roll < 95) op = cle_pkg::OP_INSERT;
      else op = cle_pkg::OP_READ;
    end else if (roll < 3) begin
      case ($urandom_range(2, 0))
        0: op = OP_SPARE_A;
        1: op = OP_SPARE_B;
        default: op = OP_SPARE_C;
      endcase
    end else begin
      if (roll < 17) op = cle_pkg::OP_LEFT;
      else if (roll < 31) op = cle_pkg::OP_RIGHT;
      else if (roll < 45) op = cle_pkg::OP_DELETE;
      else if (roll < 75) op = cle_pkg::OP_INSERT;
      else op = cle_pkg::OP_READ;
    end
    // most reads land inside the text, the rest anywhere
    if (op == cle_pkg::OP_READ && line_text.size() > 0 && $urandom_range(99, 0) < 80)
      pos = cle_pkg::POS_W'($urandom_range(line_text.size() - 1, 0));
    send_edit(op, ch, pos);
  endtask

  // edges of an empty line, unused codes, both ends of the byte range
  task automatic test_directed_edges();
    set_idling(IDLE_NONE);
    send_edit(cle_pkg::OP_READ,   8'h00, 10'd0);
    send_edit(cle_pkg::OP_LEFT,   8'h00, 10'd0);
    send_edit(cle_pkg::OP_RIGHT,  8'h00, 10'd0);
    send_edit(cle_pkg::OP_DELETE, 8'h00, 10'd0);
    send_edit(OP_SPARE_A, 8'hFF, 10'h3FF);
    send_edit(OP_SPARE_B, 8'h00, 10'd0);
    send_edit(OP_SPARE_C, 8'h3C, 10'h155);
    send_edit(cle_pkg::OP_INSERT, 8'h00, 10'd0);
    send_edit(cle_pkg::OP_INSERT, 8'hFF, 10'h3FF);
    send_edit(cle_pkg::OP_INSERT, 8'h5A, 10'd0);
    send_edit(cle_pkg::OP_READ,   8'h00, 10'd0);
    send_edit(cle_pkg::OP_READ,   8'h00, 10'd2);
    send_edit(cle_pkg::OP_READ,   8'h00, 10'd3);
    send_edit(cle_pkg::OP_READ,   8'hFF, 10'h3FF);
    send_edit(cle_pkg::OP_LEFT,   8'h00, 10'd0);
    send_edit(cle_pkg::OP_LEFT,   8'h00, 10'd0);
    send_edit(cle_pkg::OP_READ,   8'h00, 10'd1);
    send_edit(cle_pkg::OP_DELETE, 8'h00, 10'd0);
    send_edit(cle_pkg::OP_DELETE, 8'h00, 10'd0);
    send_edit(cle_pkg::OP_LEFT,   8'h00, 10'd0);
    send_edit(cle_pkg::OP_RIGHT,  8'h00, 10'd0);
    send_edit(cle_pkg::OP_RIGHT,  8'h00, 10'd0);
    send_edit(cle_pkg::OP_RIGHT,  8'h00, 10'd0);
    send_edit(cle_pkg::OP_READ,   8'h00, 10'd1);
    send_edit(cle_pkg::OP_INSERT, 8'hA5, 10'd0);
  endtask

  // receiver holds off while beats keep coming, input must stall
  task automatic test_output_backpressure();
    set_idling(IDLE_NONE);
    hold_request = 1'b1;
    repeat (12) send_random_edit(1'b0);
  endtask

  // mixed edits under each idling pattern
  task automatic test_random_edits();
    set_idling(IDLE_NONE);
    repeat (MIX_BEATS) send_random_edit(1'b0);
    set_idling(IDLE_SENDER);
    repeat (MIX_BEATS) send_random_edit(1'b0);
    set_idling(IDLE_RECEIVER);
    repeat (MIX_BEATS) send_random_edit(1'b0);
    set_idling(IDLE_BOTH);
    repeat (MIX_BEATS) send_random_edit(1'b0);
  endtask

  // fill to capacity, then inserts are refused and the far cells are read
  task automatic test_full_buffer();
    while (line_text.size() < CAPACITY) begin
      set_idling(idle_mode_t'((line_text.size() / 256) % 4));
      send_random_edit(1'b1);
    end
    set_idling(IDLE_BOTH);
    repeat (4) send_edit(cle_pkg::OP_INSERT, cle_pkg::CHAR_W'($urandom_range(255, 0)),
                         cle_pkg::POS_W'($urandom_range(1023, 0)));
    send_edit(cle_pkg::OP_LEFT,  8'h00, 10'd0);
    send_edit(cle_pkg::OP_RIGHT, 8'h00, 10'd0);
    send_edit(cle_pkg::OP_READ,  8'h00, 10'h3FF);
    send_edit(cle_pkg::OP_READ,  8'hFF, 10'd0);
    repeat (6) send_edit(cle_pkg::OP_READ, 8'h00, cle_pkg::POS_W'($urandom_range(1023, 0)));
    send_edit(cle_pkg::OP_DELETE, 8'h00, 10'd0);
    send_edit(cle_pkg::OP_INSERT, 8'hC3, 10'd0);
    send_edit(cle_pkg::OP_INSERT, 8'h3C, 10'd0);
    repeat (3) send_edit(cle_pkg::OP_LEFT, 8'h00, 10'd0);
    send_edit(cle_pkg::OP_INSERT, 8'h81, 10'd0);
    repeat (TAIL_BEATS) send_random_edit(1'b0);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_chan.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : reply_check
    editor_reply_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got len %0h cur %0h",
                 $time, out_chan.text_length, out_chan.cursor_position);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("char_out", int'(want.char_out), int'(out_chan.char_out));
        check_field("text_length", int'(want.text_length), int'(out_chan.text_length));
        check_field("cursor_position", int'(want.cursor_position),
                    int'(out_chan.cursor_position));
        check_field("refused", int'(want.refused), int'(out_chan.refused));
      end
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_chan.valid         = 1'b0;
    in_chan.operation     = cle_pkg::OP_LEFT;
    in_chan.char_in       = '0;
    in_chan.read_position = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_edges();
    test_output_backpressure();
    test_random_edits();
    test_full_buffer();
    in_chan.valid <= 1'b0;

    // drain, then give a stray beat time to show up
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
